// ----- rtl/dars_pkg.sv -----
package dars_pkg;

	typedef enum logic [1:0] {
		ST_ADDED   = 2'd0,
		ST_GRANTED = 2'd1,
		ST_EMPTY   = 2'd2,
		ST_FULL    = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		POL_FIFO  = 3'd0,
		POL_SSTF  = 3'd1,
		POL_LOOK  = 3'd2,
		POL_CLOOK = 3'd3,
		POL_FLOOK = 3'd4
	} policy_t;

	localparam logic CMD_ADD = 1'b0;
	localparam logic CMD_SEL = 1'b1;

	typedef struct packed {
		logic        cmd;
		logic [15:0] track;
		logic [15:0] req_id;
		logic [15:0] head_track;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] sel_track;
		logic [15:0] sel_id;
		logic [5:0]  pending;
		logic        dir_up;
	} rsp_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_SCAN,
		BK_PICK,
		BK_SHIFT,
		BK_DONE
	} bk_state_t;

endpackage

// ----- rtl/disk_arm_request_scheduler.sv -----
// Disk arm request scheduler. Holds up to DEPTH requests (track, id) in
// arrival order and grants one per select under the policy register
// (fifo, sstf, look, clook, flook; unused codes act as fifo). Each item
// yields one result. The command travels in s_tuser, the result status in
// m_tuser. An add, a full add or an empty select passes through the scan,
// pick and done states before its result is presented. A select that
// grants slot p scans the table one entry per cycle, picks, then
// re-reads the granted slot and shifts the entries above it down one to
// close the gap; the table has a single read port, hence the one-entry pace.
// The engine takes its next item in the cycle after its result is
// taken. A two-item input queue lets the source run ahead while the
// engine works. Write policy only when idle.
module disk_arm_request_scheduler #(
	parameter int DEPTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_data,     // policy
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic        s_tuser,      // cmd
	input  logic [47:0] s_tdata,      // track, req_id, head_track
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [1:0]  m_tuser,      // status
	output logic [39:0] m_tdata       // sel_track, sel_id, pending, dir_up, pad
);
	import dars_pkg::*;

	logic [2:0] policy_q;
	req_t in_item, q_item;
	rsp_t r_item;
	logic q_valid, q_ready;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) policy_q <= POL_FIFO;
		else if (cfg_valid && cfg_ready) policy_q <= cfg_data;
	end

	assign in_item.cmd        = s_tuser;
	assign in_item.track      = s_tdata[15:0];
	assign in_item.req_id     = s_tdata[31:16];
	assign in_item.head_track = s_tdata[47:32];

	dars_front u_front (
		.clk, .arst_n, .in_valid(s_tvalid), .in_ready(s_tready), .in_item,
		.q_valid, .q_ready, .q_item
	);

	dars_engine #(.DEPTH(DEPTH)) u_engine (
		.clk, .arst_n, .policy(policy_q), .q_valid, .q_ready, .q_item,
		.r_valid(m_tvalid), .r_ready(m_tready), .r_item
	);

	assign m_tuser = r_item.status;
	assign m_tdata = {1'b0, r_item.dir_up, r_item.pending, r_item.sel_id,
	                  r_item.sel_track};
endmodule

// ----- rtl/dars_front.sv -----
// Input side: two-entry queue between the input channel and the engine.
module dars_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  dars_pkg::req_t in_item,
	output logic          q_valid,
	input  logic          q_ready,
	output dars_pkg::req_t q_item
);
	import dars_pkg::*;

	req_t     mem_q [2];
	logic     wp_q, rp_q;
	logic [1:0] cnt_q;

	assign in_ready = cnt_q != 2'd2;
	assign q_valid  = cnt_q != 2'd0;
	assign q_item   = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) mem_q[wp_q] <= in_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
		end else begin
			if (in_valid && in_ready) wp_q <= ~wp_q;
			if (q_valid && q_ready) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(in_valid && in_ready) - 2'(q_valid && q_ready);
		end
	end
endmodule

// ----- rtl/dars_engine.sv -----
// Back end: request table in a memory; for a select, a one-entry-per-cycle
// scan, then a compaction pass that shifts younger entries down one slot.
module dars_engine #(
	parameter int DEPTH = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic [2:0]     policy,
	input  logic           q_valid,
	output logic           q_ready,
	input  dars_pkg::req_t q_item,
	output logic           r_valid,
	input  logic           r_ready,
	output dars_pkg::rsp_t r_item
);
	import dars_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [32:0] mem [DEPTH];   // {batch, id, track}

	bk_state_t st_q, st_d;
	req_t      req_q;
	logic [CW-1:0] cnt_q;
	logic      up_q, act_q;
	logic [CW-1:0] ix_q;       // scan/shift index
	logic [AW-1:0] rd_a;
	logic [32:0] rd_q;
	logic      rd_v_q;         // rd_q holds entry rd_ix_q
	logic [AW-1:0] rd_ix_q;
	// scan accumulators
	logic      anyb_q;
	logic      fu_q, fd_q, fa_q, fba_q, fbd_q;
	logic [AW-1:0] iu_q, id_q, ia_q, imn_q, iba_q, ibd_q;
	logic [15:0] du_q, dd_q, da_q, mn_q, dba_q, dbd_q;
	logic [AW-1:0] pick_q;
	rsp_t      rsp_q;
	logic      rv_q;

	logic [15:0] et, hd, span;
	logic        eb, ge, le;
	assign et   = rd_q[15:0];
	assign eb   = rd_q[32];
	assign hd   = req_q.head_track;
	assign ge   = et >= hd;
	assign le   = et <= hd;
	assign span = ge ? et - hd : hd - et;

	assign q_ready = st_q == BK_IDLE && !rv_q;
	assign r_valid = rv_q;
	assign r_item  = rsp_q;

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			BK_IDLE:  if (q_valid && q_ready) st_d = BK_SCAN;
			BK_SCAN:  if (!(req_q.cmd == CMD_SEL && cnt_q != '0)
			              || (!rd_v_q && ix_q == cnt_q && ix_q != '0)) st_d = BK_PICK;
			BK_PICK:  st_d = (req_q.cmd == CMD_SEL && cnt_q != '0) ? BK_SHIFT : BK_DONE;
			BK_SHIFT: if (rd_v_q && ix_q == cnt_q) st_d = BK_DONE;
			BK_DONE:  st_d = BK_IDLE;
			default:  st_d = BK_IDLE;
		endcase
	end

	always_comb begin
		rd_a = ix_q[AW-1:0];
	end

	always_ff @(posedge clk) begin
		rd_q <= mem[rd_a];
		rd_ix_q <= rd_a;
		if (st_q == BK_IDLE && q_valid && q_ready) req_q <= q_item;
		if (st_q == BK_PICK && req_q.cmd == CMD_ADD && cnt_q < CW'(DEPTH))
			mem[cnt_q[AW-1:0]] <= {~act_q, req_q.req_id, req_q.track};
		// entries above the granted slot move down one
		if (st_q == BK_SHIFT && rd_v_q && rd_ix_q != pick_q)
			mem[rd_ix_q - AW'(1)] <= rd_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= BK_IDLE; cnt_q <= '0; up_q <= 1'b1; act_q <= 1'b0;
			ix_q <= '0; rd_v_q <= 1'b0; rv_q <= 1'b0;
			anyb_q <= 1'b0; fu_q <= 1'b0; fd_q <= 1'b0; fa_q <= 1'b0;
			fba_q <= 1'b0; fbd_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (rv_q && r_ready) rv_q <= 1'b0;
			unique case (st_q)
				BK_IDLE: begin
					ix_q <= '0; rd_v_q <= 1'b0;
					anyb_q <= 1'b0; fu_q <= 1'b0; fd_q <= 1'b0; fa_q <= 1'b0;
					fba_q <= 1'b0; fbd_q <= 1'b0;
				end
				BK_SCAN: begin
					if (ix_q != cnt_q) ix_q <= ix_q + CW'(1);
					rd_v_q <= ix_q != cnt_q;
					if (rd_v_q) begin
						if (eb == act_q) anyb_q <= 1'b1;
						if (!fa_q || span < da_q) begin fa_q <= 1'b1; da_q <= span; ia_q <= rd_ix_q; end
						if (rd_ix_q == '0 || et < mn_q) begin mn_q <= et; imn_q <= rd_ix_q; end
						if (ge && (!fu_q || span < du_q)) begin fu_q <= 1'b1; du_q <= span; iu_q <= rd_ix_q; end
						if (le && (!fd_q || span < dd_q)) begin fd_q <= 1'b1; dd_q <= span; id_q <= rd_ix_q; end
						// batch-filtered: same batch as eventual active one
						if (ge && eb == act_q && (!fba_q || span < dba_q)) begin fba_q <= 1'b1; dba_q <= span; iba_q <= rd_ix_q; end
						if (le && eb == act_q && (!fbd_q || span < dbd_q)) begin fbd_q <= 1'b1; dbd_q <= span; ibd_q <= rd_ix_q; end
					end
				end
				BK_PICK: begin
					rsp_q.sel_track <= '0; rsp_q.sel_id <= '0;
					if (req_q.cmd == CMD_ADD) begin
						if (cnt_q < CW'(DEPTH)) begin
							cnt_q <= cnt_q + CW'(1);
							rsp_q.status <= ST_ADDED;
							rsp_q.pending <= 6'(cnt_q + CW'(1));
						end else begin
							rsp_q.status <= ST_FULL;
							rsp_q.pending <= 6'(cnt_q);
						end
						rsp_q.dir_up <= up_q;
					end else if (cnt_q == '0) begin
						rsp_q.status <= ST_EMPTY; rsp_q.pending <= '0; rsp_q.dir_up <= up_q;
					end else begin
						logic [AW-1:0] p;
						logic nu;
						p = '0; nu = up_q;
						unique case (policy)
							POL_SSTF:  p = ia_q;
							POL_LOOK:  if (up_q ? fu_q : fd_q) p = up_q ? iu_q : id_q;
							           else begin nu = ~up_q; p = up_q ? id_q : iu_q; end
							POL_CLOOK: p = fu_q ? iu_q : imn_q;
							POL_FLOOK: begin
								if (!anyb_q) begin
									// active batch empty: all entries are the other batch
									act_q <= ~act_q;
									if (up_q ? fu_q : fd_q) p = up_q ? iu_q : id_q;
									else begin nu = ~up_q; p = up_q ? id_q : iu_q; end
								end else if (up_q ? fba_q : fbd_q) p = up_q ? iba_q : ibd_q;
								else begin nu = ~up_q; p = up_q ? ibd_q : iba_q; end
							end
							default:   p = '0;
						endcase
						up_q <= nu; pick_q <= p;
						rsp_q.status <= ST_GRANTED;
						rsp_q.pending <= 6'(cnt_q - CW'(1));
						rsp_q.dir_up <= nu;
						// re-read from the granted slot: its data is the grant
						ix_q <= CW'(p); rd_v_q <= 1'b0;
					end
				end
				BK_SHIFT: begin
					if (rd_v_q && rd_ix_q == pick_q) begin
						rsp_q.sel_track <= rd_q[15:0]; rsp_q.sel_id <= rd_q[31:16];
					end
					rd_v_q <= ix_q < cnt_q;
					if (ix_q < cnt_q) ix_q <= ix_q + CW'(1);
					if (st_d == BK_DONE) cnt_q <= cnt_q - CW'(1);
				end
				BK_DONE: rv_q <= 1'b1;
				default: ;
			endcase
		end
	end
endmodule

// ----- rtl/dars_checker.sv -----
module dars_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [1:0]  m_tuser,
	input logic [39:0] m_tdata
);
	import dars_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result dropped");
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != ST_GRANTED |-> m_tdata[31:0] == 32'd0) else $error("nonzero grant");
	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[39] == 1'b0) else $error("pad");
endmodule

bind disk_arm_request_scheduler dars_checker u_chk (.*);
